### rtl/bda_pkg.sv
// Shared types and constants for the binary to decimal ASCII converter.
`timescale 1ns / 1ps

package bda_pkg;

  localparam int ValueW     = 64;
  localparam int FullDigits = 20;              // digits needed for any 64-bit value
  localparam int MaxDigits  = 20;              // digits emitted at most, 1..20
  localparam int BitsPerCyc = 4;               // binary bits folded in per cycle
  localparam int ConvSteps  = ValueW / BitsPerCyc;
  localparam int StepW      = $clog2(ConvSteps);
  localparam int DigIdxW    = $clog2(FullDigits);
  localparam int BcdW       = 4 * FullDigits;
  localparam logic [5:0] AsciiZero = 6'd48;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              mode;
  } in_t;

  typedef struct packed {
    logic [5:0] digit_char;
    logic [4:0] digit_count;
    logic       is_last;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_COUNT,
    ST_EMIT
  } state_e;

endpackage

### rtl/binary_to_decimal_ascii.sv
// Top level: 64-bit binary to decimal ASCII digit stream converter.
// The value is converted four bits per step (add-3 then shift-left) by the
//   shared double-dabble unit; the digits are then counted, then emitted.
// A new value is accepted only after the last digit of the previous one has
//   been transferred; each output transfer carries one digit, 1..20 per run.
// Reset: rst_ni clears the sequencer asynchronously; the block returns to idle
//   and ready. Data registers are not reset.
`timescale 1ns / 1ps

module binary_to_decimal_ascii (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  bda_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output bda_pkg::out_t out_data_o
);
  import bda_pkg::*;

  state_e               state_q, state_d;
  logic [StepW-1:0]     step_q, step_d;
  logic [DigIdxW-1:0]   idx_q, idx_d;      // digit being emitted, counts down
  logic [4:0]           count_q, count_d;  // digits in this run
  logic [ValueW-1:0]    bin_q, bin_d;      // binary bits still to fold in
  logic [BcdW-1:0]      bcd_q, bcd_d;      // packed BCD accumulator

  logic [ValueW-1:0]    magnitude;
  logic [ValueW-1:0]    bin_step;
  logic [BcdW-1:0]      bcd_step;
  logic [4:0]           total;
  logic [4:0]           emit_cnt;
  logic [3:0]           cur_digit;

  // Magnitude: negate only in signed mode with the sign bit set. The most
  // negative pattern wraps to itself, which read unsigned is 2^63.
  assign magnitude = (in_data_i.mode && in_data_i.value[ValueW-1]) ?
                     (~in_data_i.value + 64'd1) : in_data_i.value;

  // Shared double-dabble unit: BitsPerCyc steps of add-3 then shift-left.
  // Each step treats the twenty digits independently.
  always_comb begin
    logic [BcdW-1:0]   b;
    logic [ValueW-1:0] v;
    b = bcd_q;
    v = bin_q;
    for (int s = 0; s < BitsPerCyc; s++) begin
      for (int j = 0; j < FullDigits; j++) begin
        if (b[4*j +: 4] >= 4'd5) begin
          b[4*j +: 4] = b[4*j +: 4] + 4'd3;
        end
      end
      b = {b[BcdW-2:0], v[ValueW-1]};
      v = {v[ValueW-2:0], 1'b0};
    end
    bcd_step = b;
    bin_step = v;
  end

  // Digit count: position of the highest non-zero digit, at least one.
  always_comb begin
    total = 5'd1;
    for (int i = 0; i < FullDigits; i++) begin
      if (bcd_q[4*i +: 4] != 4'd0) begin
        total = 5'(i + 1);
      end
    end
    // Drop the most significant digits beyond the emit limit.
    emit_cnt = (total > 5'(MaxDigits)) ? 5'(MaxDigits) : total;
  end

  // Sequencer: idle, convert, count, emit.
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    idx_d   = idx_q;
    count_d = count_q;
    bin_d   = bin_q;
    bcd_d   = bcd_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          bin_d   = magnitude;
          bcd_d   = '0;
          step_d  = '0;
          state_d = ST_CONV;
        end
      end
      ST_CONV: begin
        bin_d  = bin_step;
        bcd_d  = bcd_step;
        step_d = step_q + 1'b1;
        if (step_q == StepW'(ConvSteps - 1)) begin
          state_d = ST_COUNT;
        end
      end
      ST_COUNT: begin
        count_d = emit_cnt;
        idx_d   = DigIdxW'(emit_cnt - 5'd1);
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        // Advance to the next lower digit on each output transfer.
        if (out_ready_i) begin
          if (idx_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            idx_d = idx_q - 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      idx_q   <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      idx_q   <= idx_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  // Hold the result fields steady from registers while the digit waits.
  assign cur_digit              = bcd_q[idx_q*4 +: 4];
  assign in_ready_o             = (state_q == ST_IDLE);
  assign out_valid_o            = (state_q == ST_EMIT);
  assign out_data_o.digit_char  = AsciiZero + {2'b00, cur_digit};
  assign out_data_o.digit_count = count_q;
  assign out_data_o.is_last     = (idx_q == '0);

  // A transfer in is followed by a busy block.
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted while a conversion is under way");

  // The final digit transfer returns the block to ready.
  a_ready_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && out_data_o.is_last) |=> in_ready_o)
    else $error("block not ready after last digit");

  // Emitted characters are decimal digits.
  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.digit_char >= 6'd48 && out_data_o.digit_char <= 6'd57))
    else $error("digit character out of range");

  // The digit index never reaches the run's count.
  a_idx_in_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.digit_count != 5'd0 &&
                     5'(idx_q) < out_data_o.digit_count))
    else $error("digit index beyond digit count");

endmodule
